// ===== rtl/nfba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared widths, codes and types of the next-fit bitmap allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

  localparam int MAX_CLUSTERS_DEF = 4096;
  localparam int WORD_BITS_DEF    = 64;

  localparam int FIELD_W  = 13;
  localparam int STATUS_W = 2;

  // cluster numbers start at two, bit positions at zero
  localparam logic [FIELD_W-1:0] CLUSTER_BASE = 13'd2;
  localparam logic [FIELD_W-1:0] COUNT_RESET  = 13'd4096;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL_RD,
    S_REL_CHK,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/nfba_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_cfg_if
// Register write channel: cluster count of the allocator.
// ----------------------------------------------------------------------------
interface nfba_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nfba_pkg::FIELD_W-1:0] clusters_in_use;

  modport source (output valid, clusters_in_use, input ready);
  modport sink   (input valid, clusters_in_use, output ready);
endinterface
`default_nettype wire

// ===== rtl/nfba_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_req_if
// Request channel: allocate or release beats.
// ----------------------------------------------------------------------------
interface nfba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [nfba_pkg::FIELD_W-1:0] cluster_number;

  modport source (output valid, req_type, cluster_number, input ready);
  modport sink   (input valid, req_type, cluster_number, output ready);
endinterface
`default_nettype wire

// ===== rtl/nfba_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_rsp_if
// Response channel: granted cluster and status, one beat per request.
// ----------------------------------------------------------------------------
interface nfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nfba_pkg::FIELD_W-1:0]  allocated_cluster;
  logic [nfba_pkg::STATUS_W-1:0] status;

  modport source (output valid, allocated_cluster, status, input ready);
  modport sink   (input valid, allocated_cluster, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/nfba_pos_split.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_pos_split
// Splits a bit position into bitmap word and bit offset. The word is found
// by a reciprocal multiply (exact for every position), then registered.
// ----------------------------------------------------------------------------
module nfba_pos_split #(
  parameter int MAX_CLUSTERS = nfba_pkg::MAX_CLUSTERS_DEF,
  parameter int WORD_BITS    = nfba_pkg::WORD_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   load,
  input  wire logic [$clog2(MAX_CLUSTERS)-1:0]        pos_in,
  output logic [((MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS > 1 ?
                 $clog2((MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] word_out,
  output logic [$clog2(WORD_BITS)-1:0]                bit_out
);

  localparam int PW         = $clog2(MAX_CLUSTERS);
  localparam int BW         = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int RSH        = PW + BW;
  localparam int RECIP      = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RCW        = PW + 1;
  localparam int PRW        = PW + RCW;

  logic [PW-1:0]   pos_r;
  logic [WIDX-1:0] word_r;
  logic [PRW-1:0]  prod;
  logic [PW-1:0]   word_base;
  logic [PW-1:0]   rem;

  assign prod = {{RCW{1'b0}}, pos_in} * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r  <= pos_in;
      word_r <= prod[RSH +: WIDX];
    end
  end

  assign word_base = PW'(word_r) * PW'(WORD_BITS);
  assign rem       = pos_r - word_base;
  assign word_out  = word_r;
  assign bit_out   = rem[BW-1:0];

endmodule
`default_nettype wire

// ===== rtl/next_fit_bitmap_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_bitmap_allocator
// Next-fit cluster allocator over a usage bitmap held in a word memory.
// ----------------------------------------------------------------------------
// Requests are served one at a time. An allocate reads k bitmap words,
// one per cycle through the single read port, before its result: k is 1
// when the word at the next-fit pointer has a free bit in range and at most
// WORD_COUNT + 1 on a full scan. A release goes through split, read,
// modify-write and result; an out-of-range release goes straight to the
// result. A new request is taken as soon as the previous result sits in the
// output register. After reset a clearing pass writes zero to every word
// (64 words at the defaults), while no request is taken; count writes are
// taken at any time.
module next_fit_bitmap_allocator #(
  parameter int MAX_CLUSTERS = nfba_pkg::MAX_CLUSTERS_DEF,
  parameter int WORD_BITS    = nfba_pkg::WORD_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  nfba_cfg_if.sink     cfg_ch,
  nfba_req_if.sink     in_ch,
  nfba_rsp_if.source   out_ch
);

  localparam int FW         = nfba_pkg::FIELD_W;
  localparam int PW         = $clog2(MAX_CLUSTERS);
  localparam int BW         = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CW         = $clog2(MAX_CLUSTERS + 1);
  localparam int XW         = ((CW > FW) ? CW : FW) + 1;

  // configuration and effective count
  logic [FW-1:0] cfg_count_r;
  logic [CW-1:0] count;

  assign cfg_ch.ready = 1'b1;
  assign count = (XW'(cfg_count_r) > XW'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS) : CW'(cfg_count_r);

  // bitmap memory
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic                 mem_we;
  logic [WIDX-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WIDX-1:0]      mem_raddr;
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // control state
  nfba_pkg::state_t state_r, state_nxt;
  logic [WIDX-1:0]  clr_r, clr_nxt;
  logic [WIDX-1:0]  nf_word_r, nf_word_nxt;
  logic [BW-1:0]    nf_bit_r, nf_bit_nxt;
  logic [CW-1:0]    nf_base_r, nf_base_nxt;
  logic             out_valid_r;

  // scan and result payload
  logic [WIDX-1:0]   sc_word_r, sc_word_nxt;
  logic [CW-1:0]     sc_base_r, sc_base_nxt;
  logic              sc_wrap_r, sc_wrap_nxt;
  logic              sc_first_r, sc_first_nxt;
  logic [WIDX-1:0]   st_word_r, st_word_nxt;
  logic [BW-1:0]     st_bit_r, st_bit_nxt;
  logic [FW-1:0]     res_cluster_r, res_cluster_nxt;
  nfba_pkg::status_t res_status_r, res_status_nxt;
  logic [FW-1:0]     out_cluster_r;
  nfba_pkg::status_t out_status_r;

  // release position split
  logic [FW-1:0]   rel_pos;
  logic            rel_bad;
  logic            split_load;
  logic [WIDX-1:0] split_word;
  logic [BW-1:0]   split_bit;

  assign rel_pos = in_ch.cluster_number - nfba_pkg::CLUSTER_BASE;
  assign rel_bad = (in_ch.cluster_number < nfba_pkg::CLUSTER_BASE) ||
                   (XW'(rel_pos) >= XW'(count));

  nfba_pos_split #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .WORD_BITS    (WORD_BITS)
  ) u_split (
    .clk      (clk),
    .load     (split_load),
    .pos_in   (PW'(rel_pos)),
    .word_out (split_word),
    .bit_out  (split_bit)
  );

  // next-fit start: back to zero when the pointer has fallen out of range
  logic [XW-1:0] nf_lin;
  logic          nf_out;

  assign nf_lin = XW'(nf_base_r) + XW'(nf_bit_r);
  assign nf_out = nf_lin >= XW'(count);

  // word scan
  logic [XW-1:0]        lim;
  logic                 sc_last;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] pick;
  logic [BW-1:0]        pick_idx;
  logic                 found;
  logic [XW-1:0]        pick_lin;
  logic [FW-1:0]        grant;
  logic [XW-1:0]        next_base;
  logic                 wrap_now;

  assign lim     = XW'(count) - XW'(sc_base_r);
  assign sc_last = sc_wrap_r && (sc_word_r == st_word_r);

  always_comb begin
    scan_mask = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      // in range, at or after the start on the first visit, before it on the last
      scan_mask[j] = (XW'(j) < lim) &&
                     (!sc_first_r || (BW'(j) >= st_bit_r)) &&
                     (!sc_last || (BW'(j) < st_bit_r));
    end
  end

  assign free_bits = ~rd_data_r & scan_mask;
  assign pick      = free_bits & (~free_bits + WORD_BITS'(1));
  assign found     = |free_bits;

  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (pick[j]) begin
        pick_idx = pick_idx | BW'(j);
      end
    end
  end

  assign pick_lin  = XW'(sc_base_r) + XW'(pick_idx);
  assign grant     = FW'(pick_lin + XW'(nfba_pkg::CLUSTER_BASE));
  assign next_base = XW'(sc_base_r) + XW'(WORD_BITS);
  assign wrap_now  = next_base >= XW'(count);

  logic slot_free;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == nfba_pkg::S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    nf_word_nxt     = nf_word_r;
    nf_bit_nxt      = nf_bit_r;
    nf_base_nxt     = nf_base_r;
    sc_word_nxt     = sc_word_r;
    sc_base_nxt     = sc_base_r;
    sc_wrap_nxt     = sc_wrap_r;
    sc_first_nxt    = sc_first_r;
    st_word_nxt     = st_word_r;
    st_bit_nxt      = st_bit_r;
    res_cluster_nxt = res_cluster_r;
    res_status_nxt  = res_status_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    split_load      = 1'b0;

    unique case (state_r)
      nfba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == WIDX'(WORD_COUNT - 1)) begin
          state_nxt = nfba_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + WIDX'(1);
        end
      end

      nfba_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          res_cluster_nxt = '0;
          if (in_ch.req_type == nfba_pkg::REQ_RELEASE) begin
            if (rel_bad) begin
              res_status_nxt = nfba_pkg::ST_RANGE;
              state_nxt      = nfba_pkg::S_EMIT;
            end else begin
              split_load = 1'b1;
              state_nxt  = nfba_pkg::S_REL_RD;
            end
          end else if (count == '0) begin
            res_status_nxt = nfba_pkg::ST_FULL;
            state_nxt      = nfba_pkg::S_EMIT;
          end else begin
            st_word_nxt  = nf_out ? '0 : nf_word_r;
            st_bit_nxt   = nf_out ? '0 : nf_bit_r;
            sc_word_nxt  = nf_out ? '0 : nf_word_r;
            sc_base_nxt  = nf_out ? '0 : nf_base_r;
            sc_wrap_nxt  = 1'b0;
            sc_first_nxt = 1'b1;
            mem_re       = 1'b1;
            mem_raddr    = nf_out ? '0 : nf_word_r;
            state_nxt    = nfba_pkg::S_SCAN;
          end
        end
      end

      nfba_pkg::S_SCAN: begin
        if (found) begin
          mem_we          = 1'b1;
          mem_waddr       = sc_word_r;
          mem_wdata       = rd_data_r | pick;
          nf_word_nxt     = sc_word_r;
          nf_bit_nxt      = pick_idx;
          nf_base_nxt     = sc_base_r;
          res_cluster_nxt = grant;
          res_status_nxt  = nfba_pkg::ST_OK;
          state_nxt       = nfba_pkg::S_EMIT;
        end else if (sc_last) begin
          res_status_nxt = nfba_pkg::ST_FULL;
          state_nxt      = nfba_pkg::S_EMIT;
        end else begin
          // read the next word while this one is being checked
          sc_first_nxt = 1'b0;
          mem_re       = 1'b1;
          if (wrap_now) begin
            sc_word_nxt = '0;
            sc_base_nxt = '0;
            sc_wrap_nxt = 1'b1;
            mem_raddr   = '0;
          end else begin
            sc_word_nxt = sc_word_r + WIDX'(1);
            sc_base_nxt = CW'(next_base);
            mem_raddr   = sc_word_r + WIDX'(1);
          end
        end
      end

      nfba_pkg::S_REL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = split_word;
        state_nxt = nfba_pkg::S_REL_CHK;
      end

      nfba_pkg::S_REL_CHK: begin
        if (!rd_data_r[split_bit]) begin
          res_status_nxt = nfba_pkg::ST_DOUBLE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = split_word;
          mem_wdata      = rd_data_r & ~(WORD_BITS'(1) << split_bit);
          res_status_nxt = nfba_pkg::ST_OK;
        end
        state_nxt = nfba_pkg::S_EMIT;
      end

      nfba_pkg::S_EMIT: begin
        if (slot_free) begin
          state_nxt = nfba_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = nfba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfba_pkg::S_CLEAR;
      clr_r       <= '0;
      nf_word_r   <= '0;
      nf_bit_r    <= '0;
      nf_base_r   <= '0;
      cfg_count_r <= nfba_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      nf_word_r <= nf_word_nxt;
      nf_bit_r  <= nf_bit_nxt;
      nf_base_r <= nf_base_nxt;
      if (cfg_ch.valid) begin
        cfg_count_r <= cfg_ch.clusters_in_use;
      end
      if (state_r == nfba_pkg::S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc_word_r     <= sc_word_nxt;
    sc_base_r     <= sc_base_nxt;
    sc_wrap_r     <= sc_wrap_nxt;
    sc_first_r    <= sc_first_nxt;
    st_word_r     <= st_word_nxt;
    st_bit_r      <= st_bit_nxt;
    res_cluster_r <= res_cluster_nxt;
    res_status_r  <= res_status_nxt;
    if (state_r == nfba_pkg::S_EMIT && slot_free) begin
      out_cluster_r <= res_cluster_r;
      out_status_r  <= res_status_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.allocated_cluster = out_cluster_r;
  assign out_ch.status            = out_status_r;

  // the granted bit was clear and lies inside the tracked range
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::S_SCAN && found) |->
      ((rd_data_r & pick) == '0) && $onehot(pick) && (pick_lin < XW'(count)))
    else $error("granted bit not free or out of range");

  // a successful release clears exactly one set bit
  a_release_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::S_REL_CHK && mem_we) |->
      ($countones(rd_data_r ^ mem_wdata) == 1) && ((mem_wdata & ~rd_data_r) == '0))
    else $error("release changed other bits");

  // a result leaving the emit state lands in the output register
  a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfba_pkg::S_EMIT && slot_free) |=>
      (out_valid_r && state_r == nfba_pkg::S_IDLE &&
       out_status_r == $past(res_status_r)))
    else $error("result beat lost");

  // no bitmap write outside the clearing pass, a grant or a release
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == nfba_pkg::S_CLEAR || state_r == nfba_pkg::S_SCAN ||
                state_r == nfba_pkg::S_REL_CHK))
    else $error("stray bitmap write");

endmodule
`default_nettype wire
